FILE: design/xcr_pkg.sv
// ----------------------------------------------------------------------------
// XMODEM checksum receiver package
// Shared constants, codes and types for the receiver front end, word queue
// and protocol engine.
// ----------------------------------------------------------------------------
package xcr_pkg;

  // Default payload length of one packet.
  localparam int unsigned PayloadBytesDefault = 128;

  // Register reset values.
  localparam logic [15:0] TimeoutTicksReset = 16'd1000;
  localparam logic [7:0]  RetryLimitReset   = 8'd60;

  // Configuration register indexes.
  localparam logic CfgTimeoutTicks = 1'b0;
  localparam logic CfgRetryLimit   = 1'b1;

  // Protocol characters.
  localparam logic [7:0] ChSoh  = 8'h01;
  localparam logic [7:0] ChEot  = 8'h04;
  localparam logic [7:0] ChAck  = 8'h06;
  localparam logic [7:0] ChNack = 8'h15;

  // Request codes on the input channel.
  localparam logic [1:0] ReqByte  = 2'd0;
  localparam logic [1:0] ReqTick  = 2'd1;
  localparam logic [1:0] ReqStart = 2'd2;

  // Result kinds.
  localparam logic KindPayload = 1'b0;
  localparam logic KindReply   = 1'b1;

  // Transfer end codes.
  localparam logic [1:0] EndNone  = 2'd0;
  localparam logic [1:0] EndEot   = 2'd1;
  localparam logic [1:0] EndAbort = 2'd2;

  // Depth of the queue between front end and engine.
  localparam int unsigned QueueDepth = 2;

  // Classified operation held in the queue.
  typedef enum logic [1:0] {
    OP_BYTE,
    OP_TICK,
    OP_START
  } op_e;

  // One classified word.
  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic       is_soh;
    logic       is_eot;
  } item_t;

  // Queue head as seen by the engine.
  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

  // One result word.
  typedef struct packed {
    logic       result_kind;
    logic [7:0] out_byte;
    logic [6:0] byte_offset;
    logic [7:0] block_number;
    logic [1:0] transfer_end;
  } result_t;

endpackage

FILE: design/xcr_if.sv
// ----------------------------------------------------------------------------
// XMODEM receiver channel interfaces
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------

// Request channel: received bytes, ticks and start commands.
interface xcr_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

// Result channel: payload bytes and reply bytes.
interface xcr_res_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] out_byte;
  logic [6:0] byte_offset;
  logic [7:0] block_number;
  logic [1:0] transfer_end;

  modport source (output valid, output result_kind, output out_byte,
                  output byte_offset, output block_number, output transfer_end,
                  input ready);
  modport sink   (input valid, input result_kind, input out_byte,
                  input byte_offset, input block_number, input transfer_end,
                  output ready);
endinterface

FILE: design/xcr_front.sv
// ----------------------------------------------------------------------------
// XMODEM receiver front end
// Accepts request words, drops unknown requests and classifies the rest
// into queue items with the control characters already decoded.
// ----------------------------------------------------------------------------
module xcr_front (
  xcr_req_if.sink        req,
  input  logic           q_ready_i,
  output logic           push_o,
  output xcr_pkg::item_t item_o
);

  // The front end takes a word whenever the queue has room.
  assign req.ready = q_ready_i;

  // Classify the request; unknown codes are accepted and dropped.
  always_comb begin
    push_o         = 1'b0;
    item_o.op      = xcr_pkg::OP_BYTE;
    item_o.data    = req.rx_byte;
    item_o.is_soh  = (req.rx_byte == xcr_pkg::ChSoh);
    item_o.is_eot  = (req.rx_byte == xcr_pkg::ChEot);
    unique case (req.req_type)
      xcr_pkg::ReqByte: begin
        item_o.op = xcr_pkg::OP_BYTE;
        push_o    = req.valid;
      end
      xcr_pkg::ReqTick: begin
        item_o.op = xcr_pkg::OP_TICK;
        push_o    = req.valid;
      end
      xcr_pkg::ReqStart: begin
        item_o.op = xcr_pkg::OP_START;
        push_o    = req.valid;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

endmodule

FILE: design/xcr_queue.sv
// ----------------------------------------------------------------------------
// XMODEM receiver word queue
// Small FIFO that decouples the front end from the protocol engine.
// ----------------------------------------------------------------------------
module xcr_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  xcr_pkg::item_t  item_i,
  output logic            ready_o,
  input  logic            pop_i,
  output xcr_pkg::qhead_t head_o
);

  localparam int unsigned PtrW = (xcr_pkg::QueueDepth > 1) ?
                                 $clog2(xcr_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(xcr_pkg::QueueDepth + 1);
  localparam logic [CntW-1:0] Full    = CntW'(xcr_pkg::QueueDepth);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(xcr_pkg::QueueDepth - 1);

  xcr_pkg::item_t  mem_q [xcr_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign ready_o      = (count_q != Full);
  assign do_push      = push_i && ready_o;
  assign do_pop       = pop_i && (count_q != '0);
  assign head_o.valid = (count_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage is written only on a push.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: design/xcr_engine.sv
// ----------------------------------------------------------------------------
// XMODEM receiver protocol engine
// Holds the configuration registers and the transfer state, executes one
// queued word per cycle while the output register that keeps the result word is free or being taken.
// ----------------------------------------------------------------------------
module xcr_engine #(
  parameter int unsigned PayloadBytes = xcr_pkg::PayloadBytesDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [15:0]     cfg_data_i,
  input  xcr_pkg::qhead_t head_i,
  output logic            pop_o,
  xcr_res_if.source       res
);

  localparam int unsigned IdxW = $clog2(PayloadBytes + 3);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(PayloadBytes + 2);

  // Configuration registers.
  logic [15:0] timeout_ticks_q;
  logic [7:0]  retry_limit_q;

  // Transfer state.
  logic            receiving_q, receiving_d;
  logic            in_packet_q, in_packet_d;
  logic [IdxW-1:0] byte_index_q, byte_index_d;
  logic [7:0]      expected_block_q, expected_block_d;
  logic [7:0]      received_block_q, received_block_d;
  logic [7:0]      running_sum_q, running_sum_d;
  logic [15:0]     ticks_left_q, ticks_left_d;
  logic [7:0]      retries_left_q, retries_left_d;

  // Output register.
  logic             out_valid_q, out_valid_d;
  xcr_pkg::result_t out_q, out_d;
  logic             has_result;
  xcr_pkg::result_t result;

  xcr_pkg::item_t item;

  assign item  = head_i.item;
  assign pop_o = head_i.valid && (!out_valid_q || res.ready);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_ticks_q <= xcr_pkg::TimeoutTicksReset;
      retry_limit_q   <= xcr_pkg::RetryLimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        xcr_pkg::CfgTimeoutTicks: timeout_ticks_q <= cfg_data_i;
        xcr_pkg::CfgRetryLimit:   retry_limit_q   <= cfg_data_i[7:0];
        default:                  timeout_ticks_q <= timeout_ticks_q;
      endcase
    end
  end

  // Execute the word at the head of the queue.
  always_comb begin
    receiving_d         = receiving_q;
    in_packet_d         = in_packet_q;
    byte_index_d        = byte_index_q;
    expected_block_d    = expected_block_q;
    received_block_d    = received_block_q;
    running_sum_d       = running_sum_q;
    ticks_left_d        = ticks_left_q;
    retries_left_d      = retries_left_q;
    has_result          = 1'b0;
    result.result_kind  = xcr_pkg::KindReply;
    result.out_byte     = xcr_pkg::ChNack;
    result.byte_offset  = '0;
    result.block_number = expected_block_q;
    result.transfer_end = xcr_pkg::EndNone;

    unique case (item.op)
      xcr_pkg::OP_START: begin
        receiving_d      = 1'b1;
        in_packet_d      = 1'b0;
        byte_index_d     = '0;
        running_sum_d    = '0;
        expected_block_d = 8'd1;
        ticks_left_d     = timeout_ticks_q;
        retries_left_d   = retry_limit_q;
      end

      xcr_pkg::OP_TICK: begin
        // Idle timer; a timeout costs one retry or aborts the transfer.
        if (receiving_q) begin
          if (ticks_left_q != '0) begin
            ticks_left_d = ticks_left_q - 16'd1;
          end else begin
            ticks_left_d = timeout_ticks_q;
            has_result   = 1'b1;
            if (retries_left_q != '0) begin
              retries_left_d = retries_left_q - 8'd1;
            end else begin
              receiving_d         = 1'b0;
              in_packet_d         = 1'b0;
              result.transfer_end = xcr_pkg::EndAbort;
            end
          end
        end
      end

      xcr_pkg::OP_BYTE: begin
        if (receiving_q && in_packet_q) begin
          // Walk through block number, complement, payload and checksum.
          byte_index_d = byte_index_q + IdxW'(1);
          if (byte_index_q == '0) begin
            received_block_d = item.data;
          end else if (byte_index_q == IdxW'(1)) begin
            received_block_d = received_block_q;
          end else if (byte_index_q != LastIdx) begin
            running_sum_d      = running_sum_q + item.data;
            has_result         = 1'b1;
            result.result_kind = xcr_pkg::KindPayload;
            result.out_byte    = item.data;
            result.byte_offset = 7'(byte_index_q - IdxW'(2));
          end else begin
            in_packet_d  = 1'b0;
            byte_index_d = '0;
            has_result   = 1'b1;
            if ((received_block_q == expected_block_q) &&
                (running_sum_q == item.data)) begin
              expected_block_d = expected_block_q + 8'd1;
              result.out_byte  = xcr_pkg::ChAck;
            end
          end
        end else if (receiving_q) begin
          // Between packets only SOH and EOT mean something.
          byte_index_d = '0;
          if (item.is_soh) begin
            in_packet_d    = 1'b1;
            running_sum_d  = '0;
            ticks_left_d   = timeout_ticks_q;
            retries_left_d = retry_limit_q;
          end else if (item.is_eot) begin
            receiving_d         = 1'b0;
            has_result          = 1'b1;
            result.out_byte     = xcr_pkg::ChAck;
            result.transfer_end = xcr_pkg::EndEot;
          end
        end
      end

      default: begin
        has_result = 1'b0;
      end
    endcase
  end

  // Output register: loaded on a pop, cleared when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (pop_o) begin
      out_valid_d = has_result;
      out_d       = result;
    end else if (res.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receiving_q      <= 1'b0;
      in_packet_q      <= 1'b0;
      byte_index_q     <= '0;
      expected_block_q <= 8'd1;
      received_block_q <= '0;
      running_sum_q    <= '0;
      ticks_left_q     <= '0;
      retries_left_q   <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      if (pop_o) begin
        receiving_q      <= receiving_d;
        in_packet_q      <= in_packet_d;
        byte_index_q     <= byte_index_d;
        expected_block_q <= expected_block_d;
        received_block_q <= received_block_d;
        running_sum_q    <= running_sum_d;
        ticks_left_q     <= ticks_left_d;
        retries_left_q   <= retries_left_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign res.valid        = out_valid_q;
  assign res.result_kind  = out_q.result_kind;
  assign res.out_byte     = out_q.out_byte;
  assign res.byte_offset  = out_q.byte_offset;
  assign res.block_number = out_q.block_number;
  assign res.transfer_end = out_q.transfer_end;

endmodule

FILE: design/xmodem_checksum_receiver.sv
// ----------------------------------------------------------------------------
// XMODEM checksum receiver
// Receives XMODEM packets with an 8-bit additive checksum, passes payload
// bytes on and produces ACK/NACK replies.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one word per request: a received UART byte, a millisecond
//   tick or a start command (req_type). res_o carries payload bytes with
//   their offset in the packet, and reply bytes (ACK or NACK) for the sender
//   together with the expected block number and an end-of-transfer code.
//   The configuration port sets the idle timeout in ticks and the number of
//   timeouts tolerated; write it only while no words are in flight.
//   A word is taken every cycle as long as the two-entry queue has room.
//   The engine executes one queued word per cycle while the output register
//   is free or being taken; a result passes through the queue and then the
//   output register before it reaches res_o; the sustained rate is one word per cycle.
//   When the result sink stalls, the output register holds its word, the
//   engine stops and the queue fills; req_i.ready then falls.
//   Reset empties the queue and output, restores the register defaults and
//   leaves the receiver idle with the expected block number at one.
// ----------------------------------------------------------------------------
module xmodem_checksum_receiver #(
  parameter int unsigned PayloadBytes = xcr_pkg::PayloadBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  xcr_req_if.sink     req_i,
  xcr_res_if.source   res_o
);

  logic            push;
  logic            q_ready;
  logic            pop;
  xcr_pkg::item_t  item;
  xcr_pkg::qhead_t head;

  // Front end: accept and classify.
  xcr_front u_front (
    .req       (req_i),
    .q_ready_i (q_ready),
    .push_o    (push),
    .item_o    (item)
  );

  // Queue between front end and engine.
  xcr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item),
    .ready_o (q_ready),
    .pop_i   (pop),
    .head_o  (head)
  );

  // Protocol engine with output register.
  xcr_engine #(
    .PayloadBytes (PayloadBytes)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .head_i     (head),
    .pop_o      (pop),
    .res        (res_o)
  );

  // A payload word never ends the transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.result_kind == xcr_pkg::KindPayload))
      |-> (res_o.transfer_end == xcr_pkg::EndNone))
    else $error("payload word carries an end code");

  // A reply word is always ACK or NACK.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.result_kind == xcr_pkg::KindReply))
      |-> ((res_o.out_byte == xcr_pkg::ChAck) || (res_o.out_byte == xcr_pkg::ChNack)))
    else $error("reply word is neither ACK nor NACK");

  // A completed transfer is acknowledged, an aborted one is refused.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.transfer_end != xcr_pkg::EndNone))
      |-> ((res_o.transfer_end == xcr_pkg::EndEot) ==
           (res_o.out_byte == xcr_pkg::ChAck)))
    else $error("end code and reply byte disagree");

  // The engine never pops an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid)
    else $error("engine popped an empty queue");

endmodule
